// ----- design/nnue_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnue package
// shared types, sizes and operation codes of the nnue evaluator
// ----------------------------------------------------------------------------
package nnue_pkg;

	localparam int Squares       = 64;
	localparam int InputFeatures = 1027;
	localparam int Hidden1       = 256;
	localparam int Hidden2       = 32;
	localparam int Channels      = 16;

	localparam int H1W      = $clog2(Hidden1);
	localparam int H2W      = $clog2(Hidden2);
	localparam int RowW     = $clog2(InputFeatures);
	localparam int FtDepth  = InputFeatures * Hidden1;
	localparam int L2Depth  = Hidden2 * Hidden1;
	localparam int FtAw     = $clog2(FtDepth);
	localparam int L2Aw     = $clog2(L2Depth);

	typedef enum logic [3:0] {
		OP_FTW   = 4'd0,
		OP_FTB   = 4'd1,
		OP_L2W   = 4'd2,
		OP_L2B   = 4'd3,
		OP_OUTW  = 4'd4,
		OP_RESET = 4'd5,
		OP_ADDP  = 4'd6,
		OP_REMP  = 4'd7,
		OP_ADDG  = 4'd8,
		OP_REMG  = 4'd9,
		OP_EVAL  = 4'd10
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_COPY,
		ST_L2,
		ST_L2END,
		ST_OUT,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic           walk_start;   // load item, clear index
		logic           row_step;     // one accumulator update
		logic           copy_step;    // one bias copy
		logic           l2_step;      // one layer-two product
		logic           l2_finish;    // close one layer-two sum
		logic           out_finish;   // shift, negate, present
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic j_last;
		logic k_last;
		logic pipe_empty;
	} sts_t;

	function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] s);
		asr32 = 32'($signed(x) >>> s);
	endfunction

	function automatic logic [7:0] clamp_act(input logic [31:0] x, input logic [7:0] amax);
		if (x[31])
			clamp_act = 8'd0;
		else if (x > {24'd0, amax})
			clamp_act = amax;
		else
			clamp_act = x[7:0];
	endfunction

endpackage

// ----- design/nnue_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnue controller
// sequences row walks, bias copies and evaluation over the datapath
// ----------------------------------------------------------------------------
module nnue_ctrl import nnue_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  op_t   op,
	input  logic  row_ok,
	input  logic  out_busy,
	input  sts_t  sts,
	output logic  busy,
	output cmd_t  cmd
);

	state_t state_q, state_next;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (op)
						OP_RESET: state_next = ST_COPY;
						OP_ADDP, OP_REMP, OP_ADDG, OP_REMG:
							if (row_ok) state_next = ST_ROW;
						OP_EVAL: state_next = ST_L2;
						default: state_next = ST_IDLE;
					endcase
				end
			end
			ST_ROW:   if (sts.j_last) state_next = ST_IDLE;
			ST_COPY:  if (sts.j_last) state_next = ST_IDLE;
			ST_L2:    if (sts.j_last) state_next = ST_L2END;
			ST_L2END: if (sts.pipe_empty) state_next = sts.k_last ? ST_OUT : ST_L2;
			ST_OUT:   if (!out_busy) state_next = ST_DONE;
			ST_DONE:  state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:  cmd.walk_start = start;
			ST_ROW:   cmd.row_step = 1'b1;
			ST_COPY:  cmd.copy_step = 1'b1;
			ST_L2:    cmd.l2_step = 1'b1;
			ST_L2END: cmd.l2_finish = sts.pipe_empty;
			ST_OUT:   cmd.out_finish = !out_busy;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_next;
	end

endmodule

// ----- design/nnue_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnue datapath
// weight stores, accumulator and the multiply-accumulate path
// ----------------------------------------------------------------------------
module nnue_dp import nnue_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  op_t               op,
	input  logic [18:0]       address,
	input  logic [31:0]       value,
	input  logic [RowW-1:0]   row,
	input  logic              subtract,
	input  logic              stm_white,
	input  logic [4:0]        hidden2_shift,
	input  logic [4:0]        output_shift,
	input  logic [7:0]        act_max,
	input  logic [31:0]       out_bias,
	input  cmd_t              cmd,
	output sts_t              sts,
	output logic [31:0]       score
);

	logic [15:0] ft_mem [FtDepth];
	logic [31:0] ftb_mem [Hidden1];
	logic [7:0]  l2_mem [L2Depth];
	logic [31:0] l2b_mem [Hidden2];
	logic [7:0]  ow_mem [Hidden2];
	logic [31:0] acc_mem [Hidden1];

	logic [H1W:0]    j_q;
	logic [H2W:0]    k_q;
	logic [RowW-1:0] row_q;
	logic            sub_q;
	logic            stm_q;
	logic [31:0]     sum_q;
	logic [31:0]     out_q;

	// read stage
	logic            v_s1;
	logic            kind_s1;   // 0 row/copy update, 1 layer-two product
	logic            copy_s1;
	logic [H1W-1:0]  j_s1;
	logic [15:0]     ftw_s1;
	logic [31:0]     ftb_s1;
	logic [31:0]     acc_s1;
	logic [7:0]      l2w_s1;
	// product stage
	logic            v_s2;
	logic [31:0]     prod_s2;
	logic [7:0]      ow_q;

	logic [H1W-1:0] j_idx;
	logic [H2W-1:0] k_idx;
	logic [7:0]     h2;
	logic [31:0]    o_sh;
	logic           any_step;

	// post-reset clear sweep of the accumulator
	logic [H1W:0] clr_q;
	logic         clr_busy;

	assign j_idx = j_q[H1W-1:0];
	assign k_idx = k_q[H2W-1:0];
	assign any_step = cmd.row_step | cmd.copy_step | cmd.l2_step;
	assign sts.j_last = (j_q == (H1W+1)'(Hidden1 - 1));
	assign sts.k_last = (k_q == (H2W+1)'(Hidden2 - 1));
	assign sts.pipe_empty = !v_s1 && !v_s2;
	assign clr_busy = !clr_q[H1W];

	// store writes
	always_ff @(posedge clk) begin
		if (wr_en) begin
			case (op)
				OP_FTW:  if ({13'd0, address} < 32'(FtDepth))
					ft_mem[address[FtAw-1:0]] <= value[15:0];
				OP_FTB:  if ({13'd0, address} < 32'(Hidden1))
					ftb_mem[address[H1W-1:0]] <= value;
				OP_L2W:  if ({13'd0, address} < 32'(L2Depth))
					l2_mem[address[L2Aw-1:0]] <= value[7:0];
				OP_L2B:  if ({13'd0, address} < 32'(Hidden2))
					l2b_mem[address[H2W-1:0]] <= value;
				OP_OUTW: if ({13'd0, address} < 32'(Hidden2))
					ow_mem[address[H2W-1:0]] <= value[7:0];
				default: ;
			endcase
		end
	end

	// registered reads
	always_ff @(posedge clk) begin
		ftw_s1 <= ft_mem[FtAw'({row_q, j_idx})];
		ftb_s1 <= ftb_mem[j_idx];
		acc_s1 <= acc_mem[j_idx];
		l2w_s1 <= l2_mem[L2Aw'({k_idx, j_idx})];
		ow_q   <= ow_mem[k_idx];
		j_s1   <= j_idx;
		kind_s1 <= cmd.l2_step;
		copy_s1 <= cmd.copy_step;
	end

	// accumulator write-back; accesses to one entry are a full walk apart
	always_ff @(posedge clk) begin
		if (clr_busy)
			acc_mem[clr_q[H1W-1:0]] <= 32'd0;
		else if (v_s1 && !kind_s1) begin
			if (copy_s1)
				acc_mem[j_s1] <= ftb_s1;
			else if (sub_q)
				acc_mem[j_s1] <= acc_s1 - {{16{ftw_s1[15]}}, ftw_s1};
			else
				acc_mem[j_s1] <= acc_s1 + {{16{ftw_s1[15]}}, ftw_s1};
		end
		if (v_s1 && kind_s1)
			prod_s2 <= 32'($signed(l2w_s1) * $signed({1'b0, clamp_act(acc_s1, act_max)}));
	end

	assign h2 = clamp_act(asr32(sum_q, hidden2_shift), act_max);
	assign o_sh = asr32(out_q, output_shift);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
			k_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			clr_q <= '0;
		end else begin
			if (clr_busy)
				clr_q <= clr_q + 1'b1;
			v_s1 <= any_step;
			v_s2 <= v_s1 && kind_s1;
			if (cmd.walk_start) begin
				j_q <= '0;
				k_q <= '0;
			end else if (any_step) begin
				j_q <= sts.j_last ? '0 : j_q + 1'b1;
			end else if (cmd.l2_finish) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			row_q <= row;
			sub_q <= subtract;
			stm_q <= stm_white;
			out_q <= out_bias;
		end
		if (cmd.l2_step && j_q == '0)
			sum_q <= l2b_mem[k_idx];
		else if (v_s2)
			sum_q <= sum_q + prod_s2;
		if (cmd.l2_finish)
			out_q <= out_q + 32'($signed(ow_q) * $signed({1'b0, h2}));
		if (cmd.out_finish) begin
			if (stm_q)
				score <= o_sh;
			else if (o_sh == 32'h8000_0000)
				score <= 32'h7fff_ffff;
			else
				score <= 32'd0 - o_sh;
		end
	end

endmodule

// ----- design/nnue_accumulator_and_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnue accumulator and evaluator
// quantized nnue with incremental accumulator and two-layer evaluation
// ----------------------------------------------------------------------------
// channel   dir  contents
// s_axis    in   operation, address, value, square, piece_code, feature, stm
// m_axis    out  score
// apb       in   hidden2_shift, output_shift, act_max, out_bias
//
// store writes leave the input ready for the next transfer; feature updates
// and accumulator reset walk Hidden1 entries before the next transfer is taken;
// evaluation walks Hidden2 x Hidden1 layer-two weights through one multiplier.
// after reset the input waits while a sweep clears the accumulator.
// the score waits in an output register; a stalled output holds the next eval.
// ----------------------------------------------------------------------------
module nnue_accumulator_and_eval import nnue_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [3:0] operation, [22:4] address, [54:23] value, [60:55] square,
	// [65:61] piece_code, [76:66] feature, [77] side_to_move_white
	input  logic [79:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] score
	output logic [31:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [4:0]  hidden2_shift_q, output_shift_q;
	logic [7:0]  act_max_q;
	logic [31:0] out_bias_q;
	logic        busy, accept, row_ok, ovalid_q, clr_done_q;
	logic [8:0]  clr_cnt_q;
	op_t         op;
	logic [5:0]  square;
	logic signed [4:0] code;
	logic [4:0]  mag;
	logic [3:0]  ch;
	logic [RowW-1:0] prow, row;
	logic [10:0] feature;
	cmd_t        cmd;
	sts_t        sts;
	logic [31:0] score;

	assign pready = 1'b1;
	assign op = op_t'(s_axis_tdata[3:0]);
	assign square = s_axis_tdata[60:55];
	assign code = s_axis_tdata[65:61];
	assign feature = s_axis_tdata[76:66];
	assign s_axis_tready = !busy && clr_done_q;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = score;

	always_comb begin
		mag = code[4] ? 5'(-code) : code;
		case (mag)
			5'd7:    ch = code[4] ? 4'd14 : 4'd6;
			5'd8:    ch = code[4] ? 4'd15 : 4'd7;
			default: ch = 4'(mag - 5'd1) + (code[4] ? 4'd8 : 4'd0);
		endcase
		prow = RowW'({square, ch});
		if (op == OP_ADDP || op == OP_REMP) begin
			row = prow;
			row_ok = mag != 5'd0 && mag <= 5'd8 && 32'(square) < 32'(Squares)
				&& 32'(prow) < 32'(InputFeatures);
		end else begin
			row = feature;
			row_ok = 32'(feature) < 32'(InputFeatures);
		end
	end

	nnue_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(accept), .op(op), .row_ok(row_ok),
		.out_busy(ovalid_q), .sts(sts), .busy(busy), .cmd(cmd)
	);

	nnue_dp u_dp (
		.clk(clk), .arst_n(arst_n), .wr_en(accept), .op(op),
		.address(s_axis_tdata[22:4]), .value(s_axis_tdata[54:23]), .row(row),
		.subtract(op == OP_REMP || op == OP_REMG), .stm_white(s_axis_tdata[77]),
		.hidden2_shift(hidden2_shift_q), .output_shift(output_shift_q),
		.act_max(act_max_q), .out_bias(out_bias_q), .cmd(cmd), .sts(sts),
		.score(score)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			clr_cnt_q <= '0;
			clr_done_q <= 1'b0;
			hidden2_shift_q <= '0;
			output_shift_q <= '0;
			act_max_q <= 8'd127;
			out_bias_q <= '0;
		end else begin
			if (!clr_done_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == 9'(Hidden1)) clr_done_q <= 1'b1;
			end
			if (cmd.out_finish)
				ovalid_q <= 1'b1;
			else if (m_axis_tready)
				ovalid_q <= 1'b0;
			if (psel && penable && pwrite) begin
				case (paddr)
					4'd0:    hidden2_shift_q <= pwdata[4:0];
					4'd4:    output_shift_q <= pwdata[4:0];
					4'd8:    act_max_q <= pwdata[7:0];
					4'd12:   out_bias_q <= pwdata;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (paddr)
			4'd0:    prdata = {27'd0, hidden2_shift_q};
			4'd4:    prdata = {27'd0, output_shift_q};
			4'd8:    prdata = {24'd0, act_max_q};
			4'd12:   prdata = out_bias_q;
			default: prdata = '0;
		endcase
	end

endmodule
